// ===== sv/wcs_pkg.sv =====
// ----------------------------------------------------------------------------
// wcs_pkg
// Shared types, constants and the shade lookup for the wall column shader.
// ----------------------------------------------------------------------------
package wcs_pkg;

  localparam int ROWS     = 32;
  localparam int ROW_W    = 6;
  localparam int DIST_W   = 16;
  localparam int SHADE_W  = 3;
  localparam int K_W      = ROW_W;
  localparam int PROD_W   = DIST_W + K_W;
  localparam int CENTER   = ROWS / 2;
  localparam int DIST_ONE = 256;
  localparam int SPAN_NUM = CENTER * DIST_ONE;

  localparam logic [SHADE_W-1:0] SHADE_BG = 3'd0;
  localparam logic [SHADE_W-1:0] SHADE_D1 = 3'd1;
  localparam logic [SHADE_W-1:0] SHADE_D2 = 3'd2;
  localparam logic [SHADE_W-1:0] SHADE_D3 = 3'd3;
  localparam logic [SHADE_W-1:0] SHADE_D4 = 3'd4;
  localparam logic [SHADE_W-1:0] SHADE_D5 = 3'd5;
  localparam logic [SHADE_W-1:0] SHADE_D6 = 3'd6;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              empty_column;
  } in_item_t;

  typedef struct packed {
    logic [SHADE_W-1:0] shade;
    logic [ROW_W-1:0]   row;
    logic               last_row;
  } out_item_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              empty_column;
    logic [ROW_W-1:0]  row;
    logic              last_row;
  } row_item_t;

  function automatic logic [SHADE_W-1:0] shade_for(input logic [DIST_W-1:0] d);
    logic [SHADE_W-1:0] s;
    if (d > DIST_W'(5 * DIST_ONE)) s = SHADE_D6;
    else if (d > DIST_W'(4 * DIST_ONE)) s = SHADE_D5;
    else if (d > DIST_W'(3 * DIST_ONE)) s = SHADE_D4;
    else if (d > DIST_W'(2 * DIST_ONE)) s = SHADE_D3;
    else if (d > DIST_W'(DIST_ONE)) s = SHADE_D2;
    else s = SHADE_D1;
    return s;
  endfunction

endpackage

// ===== sv/wcs_row_gen.sv =====
// ----------------------------------------------------------------------------
// wcs_row_gen
// Column sequencer: holds one column and issues its rows one per cycle on adv.
// ----------------------------------------------------------------------------
module wcs_row_gen (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  wcs_pkg::in_item_t   in_data,
  output logic                in_stall,
  input  logic                adv,
  output logic                s0_valid,
  output wcs_pkg::row_item_t  s0_item
);
  import wcs_pkg::*;

  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

  logic              active_r, active_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [DIST_W-1:0] dist_r, dist_nxt;
  logic              empty_r, empty_nxt;
  logic              is_last;
  logic              take;

  assign is_last  = (row_r == LAST_ROW);
  assign in_stall = active_r && !(adv && is_last);
  assign take     = in_valid && !in_stall;

  always_comb begin
    active_nxt = active_r;
    row_nxt    = row_r;
    dist_nxt   = dist_r;
    empty_nxt  = empty_r;
    if (take) begin
      active_nxt = 1'b1;
      row_nxt    = '0;
      dist_nxt   = in_data.distance;
      empty_nxt  = in_data.empty_column;
    end else if (adv && active_r) begin
      row_nxt = row_r + 1'b1;
      if (is_last) begin
        active_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      row_r    <= '0;
    end else begin
      active_r <= active_nxt;
      row_r    <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dist_r  <= dist_nxt;
    empty_r <= empty_nxt;
  end

  assign s0_valid              = active_r;
  assign s0_item.distance      = dist_r;
  assign s0_item.empty_column  = empty_r;
  assign s0_item.row           = row_r;
  assign s0_item.last_row      = is_last;

endmodule

// ===== sv/wcs_span_pipe.sv =====
// ----------------------------------------------------------------------------
// wcs_span_pipe
// Three-stage row shader: offset and shade, offset times distance, span test.
// ----------------------------------------------------------------------------
module wcs_span_pipe (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                s0_valid,
  input  wcs_pkg::row_item_t  s0_item,
  output logic                out_valid,
  output wcs_pkg::out_item_t  out_data
);
  import wcs_pkg::*;

  typedef struct packed {
    logic [K_W-1:0]     k;
    logic [DIST_W-1:0]  distance;
    logic               zero;
    logic               empty;
    logic [SHADE_W-1:0] shade;
    logic [ROW_W-1:0]   row;
    logic               last;
  } s1_t;

  typedef struct packed {
    logic [PROD_W-1:0]  prod;
    logic               zero;
    logic               empty;
    logic [SHADE_W-1:0] shade;
    logic [ROW_W-1:0]   row;
    logic               last;
  } s2_t;

  localparam logic [ROW_W-1:0]  CENTER_ROW = ROW_W'(CENTER);
  localparam logic [PROD_W-1:0] SPAN_LIM   = PROD_W'(SPAN_NUM);

  logic      v1_r, v1_nxt, v2_r, v2_nxt, v3_r, v3_nxt;
  s1_t       s1_r, s1_nxt;
  s2_t       s2_r, s2_nxt;
  out_item_t s3_r, s3_nxt;
  logic      in_span;

  always_comb begin
    s1_nxt.k        = (s0_item.row >= CENTER_ROW) ? K_W'(s0_item.row - CENTER_ROW)
                                                  : K_W'(CENTER_ROW - s0_item.row);
    s1_nxt.distance = s0_item.distance;
    s1_nxt.zero     = (s0_item.distance == '0);
    s1_nxt.empty    = s0_item.empty_column;
    s1_nxt.shade    = shade_for(s0_item.distance);
    s1_nxt.row      = s0_item.row;
    s1_nxt.last     = s0_item.last_row;

    s2_nxt.prod  = PROD_W'(s1_r.k) * PROD_W'(s1_r.distance);
    s2_nxt.zero  = s1_r.zero;
    s2_nxt.empty = s1_r.empty;
    s2_nxt.shade = s1_r.shade;
    s2_nxt.row   = s1_r.row;
    s2_nxt.last  = s1_r.last;

    in_span         = s2_r.zero || (s2_r.prod <= SPAN_LIM);
    s3_nxt.shade    = (!s2_r.empty && in_span) ? s2_r.shade : SHADE_BG;
    s3_nxt.row      = s2_r.row;
    s3_nxt.last_row = s2_r.last;

    v1_nxt = adv ? s0_valid : v1_r;
    v2_nxt = adv ? v1_r : v2_r;
    v3_nxt = adv ? v2_r : v3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
      s3_r <= s3_nxt;
    end
  end

  assign out_valid = v3_r;
  assign out_data  = s3_r;

endmodule

// ===== sv/wall_column_shader_top.sv =====
// Row 0 of an accepted column passes the sequencer, s1, s2 and s3 registers.
// Throughput: one row per cycle while out_stall does not hold the output; the row
// sequencer takes the next column in the cycle its last row moves on.
// Reset: synchronous, active low; clears the sequencer and all stage valid bits.
// ----------------------------------------------------------------------------
// wall_column_shader_top
// Turns a wall distance per screen column into a shade code per row.
// ----------------------------------------------------------------------------
module wall_column_shader_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  wcs_pkg::in_item_t   in_data,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output wcs_pkg::out_item_t  out_data
);
  import wcs_pkg::*;

  logic      adv;
  logic      s0_valid;
  row_item_t s0_item;

  assign adv = !out_valid || !out_stall;

  wcs_row_gen u_row_gen (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .adv      (adv),
    .s0_valid (s0_valid),
    .s0_item  (s0_item)
  );

  wcs_span_pipe u_span_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .s0_valid  (s0_valid),
    .s0_item   (s0_item),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ===== sv/wcs_checker.sv =====
// ----------------------------------------------------------------------------
// wcs_checker
// Port-level checks on the result stream of the wall column shader.
// ----------------------------------------------------------------------------
module wcs_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                out_valid,
  input  logic                out_stall,
  input  wcs_pkg::out_item_t  out_data
);
  import wcs_pkg::*;

  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

  logic [ROW_W-1:0] exp_row_r, exp_row_nxt;
  logic             out_take;

  assign out_take = out_valid && !out_stall;

  always_comb begin
    exp_row_nxt = exp_row_r;
    if (out_take) begin
      exp_row_nxt = (exp_row_r == LAST_ROW) ? '0 : exp_row_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_row_r <= '0;
    end else begin
      exp_row_r <= exp_row_nxt;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result transaction changed");

  a_row_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.row == exp_row_r)
    else $error("result row out of sequence");

  a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.last_row == (out_data.row == LAST_ROW))
    else $error("last_row flag does not match row index");

  a_shade_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.shade <= SHADE_D6)
    else $error("shade code out of range");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind wall_column_shader_top wcs_checker u_wcs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
